/* hw/rtl/ctf_pkg.sv */
package ctf_pkg;

  // Table size and index width
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Action codes
  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_ACCEPT  = 3'd1;
  localparam logic [2:0] ACT_SEGMENT = 3'd2;
  localparam logic [2:0] ACT_CLOSE   = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;

  // Segment kinds
  localparam logic [1:0] SEG_SYN = 2'd0;
  localparam logic [1:0] SEG_FIN = 2'd2;

  // Reply kinds
  localparam logic RPL_SYNACK = 1'b0;
  localparam logic RPL_FINACK = 1'b1;

  // Entry phases
  localparam logic [1:0] PH_CLOSED = 2'd0;
  localparam logic [1:0] PH_LISTEN = 2'd1;
  localparam logic [1:0] PH_CONN   = 2'd2;
  localparam logic [1:0] PH_WAIT   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_NOMATCH    = 3'd2;
  localparam logic [2:0] ST_IGNORED    = 3'd3;
  localparam logic [2:0] ST_WRONGSTATE = 3'd4;
  localparam logic [2:0] ST_NOTALLOC   = 3'd5;

  localparam logic [15:0] CLOSEWAIT_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  socket_id;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [1:0]  seg_kind;
  } ctf_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [1:0]  entry_phase;
    logic        reply_valid;
    logic        reply_kind;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dst_port;
  } ctf_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic find;
    logic exec;
  } ctf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic known;
  } ctf_stat_t;

endpackage

/* hw/rtl/ctf_ctrl.sv */
module ctf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              cfg_ready,
  input  ctf_pkg::ctf_stat_t stat,
  output ctf_pkg::ctf_cmd_t  cmd
);
  import ctf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Sequence capture, search, execute
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_FIND;
      S_FIND: state_nxt = stat.known ? S_EXEC : S_IDLE;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cfg_ready   = (state_r == S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.find    = (state_r == S_FIND);
  assign cmd.exec    = (state_r == S_EXEC);

endmodule

/* hw/rtl/ctf_dp.sv */
module ctf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ctf_pkg::ctf_cmd_t  cmd,
  output ctf_pkg::ctf_stat_t stat,
  input  ctf_pkg::ctf_in_t   in_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  output logic               out_strobe,
  output ctf_pkg::ctf_out_t  out_item
);
  import ctf_pkg::*;

  ctf_in_t            item_r;
  logic [15:0]        ticks_r;
  logic [IDX_W-1:0]   sel_r;
  logic               hit_r;
  logic               strobe_r;
  ctf_out_t           res_r, res_nxt;

  logic               used_r  [ENTRIES];
  logic [1:0]         phase_r [ENTRIES];
  logic [15:0]        sport_r [ENTRIES];
  logic [15:0]        cport_r [ENTRIES];
  logic [15:0]        cnt_r   [ENTRIES];

  logic               used_nxt  [ENTRIES];
  logic [1:0]         phase_nxt [ENTRIES];
  logic [15:0]        cport_nxt [ENTRIES];
  logic [15:0]        cnt_nxt   [ENTRIES];
  logic               sport_we  [ENTRIES];

  logic               free_hit, match_hit, sid_ok;
  logic [IDX_W-1:0]   free_idx, match_idx;
  logic [IDX_W-1:0]   sel_nxt;
  logic               hit_nxt;

  logic               e_used;
  logic [1:0]         e_phase;
  logic [15:0]        e_sport, e_cport;
  logic               ok_addr;
  logic [3:0]         e_index;

  // Classify the captured action
  assign stat.known = (item_r.action == ACT_CREATE) || (item_r.action == ACT_ACCEPT) ||
                      (item_r.action == ACT_SEGMENT) || (item_r.action == ACT_CLOSE) ||
                      (item_r.action == ACT_TICK);

  // Hold the item and the timeout register
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= CLOSEWAIT_RESET;
    end else if (cfg_we) begin
      ticks_r <= cfg_data;
    end
  end

  // Search lowest free entry and lowest port match in parallel
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (used_r[i] && (sport_r[i] == item_r.local_port)) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  assign sid_ok = (32'(item_r.socket_id) < 32'(ENTRIES));

  always_comb begin
    sel_nxt = IDX_W'(item_r.socket_id);
    hit_nxt = sid_ok;
    case (item_r.action)
      ACT_CREATE: begin
        sel_nxt = free_idx;
        hit_nxt = free_hit;
      end
      ACT_SEGMENT: begin
        sel_nxt = match_idx;
        hit_nxt = match_hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      sel_r <= sel_nxt;
      hit_r <= hit_nxt;
    end
  end

  // Read the selected entry
  assign e_used  = used_r[sel_r];
  assign e_phase = phase_r[sel_r];
  assign e_sport = sport_r[sel_r];
  assign e_cport = cport_r[sel_r];
  assign ok_addr = hit_r && e_used;
  assign e_index = 4'(sel_r);

  // Build the result
  always_comb begin
    res_nxt = '0;
    case (item_r.action)
      ACT_CREATE: begin
        res_nxt.status = hit_r ? ST_OK : ST_FULL;
        if (hit_r) res_nxt.entry_index = e_index;
      end
      ACT_ACCEPT: begin
        res_nxt.entry_index = item_r.socket_id;
        if (ok_addr) begin
          res_nxt.status      = ST_OK;
          res_nxt.entry_phase = PH_LISTEN;
        end else begin
          res_nxt.status      = ST_NOTALLOC;
        end
      end
      ACT_SEGMENT: begin
        if (!hit_r) begin
          res_nxt.status = ST_NOMATCH;
        end else begin
          res_nxt.entry_index = e_index;
          if ((item_r.seg_kind == SEG_SYN) &&
              ((e_phase == PH_LISTEN) || (e_phase == PH_CONN))) begin
            res_nxt.status         = ST_OK;
            res_nxt.entry_phase    = PH_CONN;
            res_nxt.reply_valid    = 1'b1;
            res_nxt.reply_kind     = RPL_SYNACK;
            res_nxt.reply_src_port = e_sport;
            res_nxt.reply_dst_port = (e_phase == PH_LISTEN) ? item_r.remote_port : e_cport;
          end else if ((item_r.seg_kind == SEG_FIN) &&
                       ((e_phase == PH_CONN) || (e_phase == PH_WAIT))) begin
            res_nxt.status         = ST_OK;
            res_nxt.entry_phase    = PH_WAIT;
            res_nxt.reply_valid    = 1'b1;
            res_nxt.reply_kind     = RPL_FINACK;
            res_nxt.reply_src_port = e_sport;
            res_nxt.reply_dst_port = e_cport;
          end else begin
            res_nxt.status      = ST_IGNORED;
            res_nxt.entry_phase = e_phase;
          end
        end
      end
      ACT_CLOSE: begin
        res_nxt.entry_index = item_r.socket_id;
        if (ok_addr) begin
          res_nxt.status = (e_phase == PH_CLOSED) ? ST_OK : ST_WRONGSTATE;
        end else begin
          res_nxt.status = ST_NOTALLOC;
        end
      end
      default: res_nxt.status = ST_OK;
    endcase
  end

  // Compute per-entry updates
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      used_nxt[i]  = used_r[i];
      phase_nxt[i] = phase_r[i];
      cport_nxt[i] = cport_r[i];
      cnt_nxt[i]   = cnt_r[i];
      sport_we[i]  = 1'b0;
      if (cmd.exec) begin
        if (item_r.action == ACT_TICK) begin
          if (used_r[i] && (phase_r[i] == PH_WAIT)) begin
            if (cnt_r[i] <= 16'd1) begin
              cnt_nxt[i]   = '0;
              phase_nxt[i] = PH_CLOSED;
            end else begin
              cnt_nxt[i]   = cnt_r[i] - 16'd1;
            end
          end
        end else if (sel_r == IDX_W'(i)) begin
          case (item_r.action)
            ACT_CREATE: if (hit_r) begin
              used_nxt[i]  = 1'b1;
              phase_nxt[i] = PH_CLOSED;
              cport_nxt[i] = '0;
              cnt_nxt[i]   = '0;
              sport_we[i]  = 1'b1;
            end
            ACT_ACCEPT: if (ok_addr) begin
              phase_nxt[i] = PH_LISTEN;
              cnt_nxt[i]   = '0;
            end
            ACT_SEGMENT: if (hit_r) begin
              if ((item_r.seg_kind == SEG_SYN) && (phase_r[i] == PH_LISTEN)) begin
                phase_nxt[i] = PH_CONN;
                cport_nxt[i] = item_r.remote_port;
              end else if ((item_r.seg_kind == SEG_FIN) && (phase_r[i] == PH_CONN)) begin
                phase_nxt[i] = PH_WAIT;
                cnt_nxt[i]   = ticks_r;
              end
            end
            ACT_CLOSE: if (ok_addr) begin
              used_nxt[i]  = 1'b0;
              phase_nxt[i] = PH_CLOSED;
              cport_nxt[i] = '0;
              cnt_nxt[i]   = '0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Update the entry table
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (!rst_n) begin
        used_r[i]  <= 1'b0;
        phase_r[i] <= PH_CLOSED;
        cport_r[i] <= '0;
        cnt_r[i]   <= '0;
      end else begin
        used_r[i]  <= used_nxt[i];
        phase_r[i] <= phase_nxt[i];
        cport_r[i] <= cport_nxt[i];
        cnt_r[i]   <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (sport_we[i]) sport_r[i] <= item_r.local_port;
    end
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (cmd.exec) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.exec;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = res_r;

endmodule

/* hw/rtl/connection_table_fsm_unit.sv */
// Each item is captured in the idle state, then passes the search and execute states: the entry search is
// registered before the read-modify-write of the selected entry. A new item is taken
// only when the block is idle again. Unknown actions end after the search and give no result.
// Reset (synchronous, rst_n low) frees all entries and loads the close-wait
// timeout with 1000. The receiver cannot stall: each result shows for one cycle.
module connection_table_fsm_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ctf_pkg::ctf_in_t  in_item,
  output logic              out_strobe,
  output ctf_pkg::ctf_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import ctf_pkg::*;

  ctf_cmd_t  cmd;
  ctf_stat_t stat;

  // Sequence each transfer
  ctf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the table and build results
  ctf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_item    (in_item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

/* tb/connection_table_fsm_unit_test.sv */
`timescale 1ns / 1ps

module connection_table_fsm_unit_test;
  import ctf_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 255;
  localparam int DRAIN_SLACK = 4;

  // Track the connection table and the replies still owed by the block
  class conn_table_tracker;
    bit          used[ENTRIES];
    logic [1:0]  phase[ENTRIES];
    logic [15:0] server_port[ENTRIES];
    logic [15:0] client_port[ENTRIES];
    logic [15:0] countdown[ENTRIES];
    logic [15:0] close_ticks;
    int          errors;
    ctf_out_t    expected_replies[$];

    function new();
      close_ticks = CLOSEWAIT_RESET;
      errors = 0;
      foreach (used[i]) begin
        used[i] = 1'b0;
        phase[i] = PH_CLOSED;
        server_port[i] = '0;
        client_port[i] = '0;
        countdown[i] = '0;
      end
    endfunction

    function int first_free();
      for (int i = 0; i < ENTRIES; i++)
        if (!used[i]) return i;
      return ENTRIES;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Advance the table by one accepted event and queue its reply
    function void apply_event(ctf_in_t ev);
      ctf_out_t r;
      int hit;
      r = '0;
      case (ev.action)
        ACT_CREATE: begin
          hit = first_free();
          if (hit < ENTRIES) begin
            used[hit] = 1'b1;
            phase[hit] = PH_CLOSED;
            server_port[hit] = ev.local_port;
            client_port[hit] = '0;
            countdown[hit] = '0;
            r.status = ST_OK;
            r.entry_index = hit[3:0];
            r.entry_phase = PH_CLOSED;
          end else begin
            r.status = ST_FULL;
          end
        end
        ACT_ACCEPT: begin
          r.entry_index = ev.socket_id;
          if (int'(ev.socket_id) >= ENTRIES || !used[ev.socket_id]) begin
            r.status = ST_NOTALLOC;
          end else begin
            phase[ev.socket_id] = PH_LISTEN;
            countdown[ev.socket_id] = '0;
            r.status = ST_OK;
            r.entry_phase = PH_LISTEN;
          end
        end
        ACT_SEGMENT: begin
          hit = ENTRIES;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (used[i] && server_port[i] == ev.local_port) hit = i;
          if (hit == ENTRIES) begin
            r.status = ST_NOMATCH;
          end else begin
            r.entry_index = hit[3:0];
            if (ev.seg_kind == SEG_SYN &&
                (phase[hit] == PH_LISTEN || phase[hit] == PH_CONN)) begin
              if (phase[hit] == PH_LISTEN) begin
                phase[hit] = PH_CONN;
                client_port[hit] = ev.remote_port;
              end
              r.reply_valid = 1'b1;
              r.reply_kind = RPL_SYNACK;
            end else if (ev.seg_kind == SEG_FIN &&
                         (phase[hit] == PH_CONN || phase[hit] == PH_WAIT)) begin
              // a repeated FIN keeps the running timer
              if (phase[hit] == PH_CONN) begin
                phase[hit] = PH_WAIT;
                countdown[hit] = close_ticks;
              end
              r.reply_valid = 1'b1;
              r.reply_kind = RPL_FINACK;
            end
            r.status = r.reply_valid ? ST_OK : ST_IGNORED;
            r.entry_phase = phase[hit];
            if (r.reply_valid) begin
              r.reply_src_port = server_port[hit];
              r.reply_dst_port = client_port[hit];
            end
          end
        end
        ACT_CLOSE: begin
          r.entry_index = ev.socket_id;
          if (int'(ev.socket_id) >= ENTRIES || !used[ev.socket_id]) begin
            r.status = ST_NOTALLOC;
          end else begin
            r.status = (phase[ev.socket_id] == PH_CLOSED) ? ST_OK : ST_WRONGSTATE;
            used[ev.socket_id] = 1'b0;
            phase[ev.socket_id] = PH_CLOSED;
            client_port[ev.socket_id] = '0;
            countdown[ev.socket_id] = '0;
          end
        end
        ACT_TICK: begin
          // a countdown of 0 or 1 expires on this tick
          for (int i = 0; i < ENTRIES; i++) begin
            if (used[i] && phase[i] == PH_WAIT) begin
              if (countdown[i] <= 16'd1) begin
                countdown[i] = '0;
                phase[i] = PH_CLOSED;
              end else begin
                countdown[i] = countdown[i] - 16'd1;
              end
            end
          end
          r.status = ST_OK;
        end
        default: return;
      endcase
      expected_replies.push_back(r);
    endfunction

    // Compare one strobed reply against the oldest queued one
    function void check_result(ctf_out_t got);
      ctf_out_t want;
      if (expected_replies.size() == 0) begin
        if (errors < 10)
          $display("[%0t] unexpected reply st=%0d idx=%0d ph=%0d", $realtime,
                   got.status, got.entry_index, got.entry_phase);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.entry_index !== want.entry_index ||
          got.entry_phase !== want.entry_phase ||
          got.reply_valid !== want.reply_valid ||
          got.reply_kind !== want.reply_kind ||
          got.reply_src_port !== want.reply_src_port ||
          got.reply_dst_port !== want.reply_dst_port) begin
        if (errors < 10) begin
          $display("[%0t] reply mismatch, exp st=%0d idx=%0d ph=%0d rv=%b rk=%b src=%h dst=%h",
                   $realtime, want.status, want.entry_index, want.entry_phase,
                   want.reply_valid, want.reply_kind, want.reply_src_port,
                   want.reply_dst_port);
          $display("    got st=%0d idx=%0d ph=%0d rv=%b rk=%b src=%h dst=%h",
                   got.status, got.entry_index, got.entry_phase, got.reply_valid,
                   got.reply_kind, got.reply_src_port, got.reply_dst_port);
        end
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ctf_in_t     in_item = '0;
  logic        out_strobe;
  ctf_out_t    out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  conn_table_tracker tracker;
  int sent_count = 0;
  int stall_cycles = 0;
  bit allow_idle = 1'b1;

  connection_table_fsm_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every strobed reply
  always @(posedge clk) begin
    if (rst_n && out_strobe) tracker.check_result(out_item);
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic ctf_in_t make_event(logic [2:0] action, logic [3:0] sid,
                                         logic [15:0] lport, logic [15:0] rport,
                                         logic [1:0] kind);
    ctf_in_t ev;
    ev.action = action;
    ev.socket_id = sid;
    ev.local_port = lport;
    ev.remote_port = rport;
    ev.seg_kind = kind;
    return ev;
  endfunction

  // Favor a few ports so segments find their entries
  function automatic logic [15:0] pick_port();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0050;
      3: return 16'h1F90;
      4: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one event and hold it until the block takes it
  task automatic send_event(input ctf_in_t ev);
    int gap;
    gap = 0;
    if (allow_idle && $urandom_range(99) < 14) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= ev;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.apply_event(ev);
    if (ev.action <= ACT_TICK) sent_count++;
  endtask

  // Drop start and wait for every owed reply
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    drain();
    repeat (DRAIN_SLACK) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.close_ticks = value;
  endtask

  // Mostly full connection lifecycles, mixed with noise, tick runs and table fills
  task automatic run_phase(input int target);
    int base, sel, sid, reps;
    logic [15:0] port;
    base = sent_count;
    while (sent_count - base < target) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        if (tracker.first_free() >= ENTRIES)
          send_event(make_event(ACT_CLOSE, 4'($urandom_range(ENTRIES - 1)),
                                16'($urandom), 16'($urandom), 2'($urandom)));
        sid = tracker.first_free();
        port = pick_port();
        send_event(make_event(ACT_CREATE, 4'($urandom), port, 16'($urandom),
                              2'($urandom)));
        send_event(make_event(ACT_ACCEPT, sid[3:0], 16'($urandom), 16'($urandom),
                              2'($urandom)));
        if ($urandom_range(9) < 9)
          send_event(make_event(ACT_SEGMENT, 4'($urandom), port, 16'($urandom),
                                SEG_SYN));
        if ($urandom_range(3) == 0)
          send_event(make_event(ACT_SEGMENT, 4'($urandom), port, 16'($urandom),
                                SEG_SYN));
        if ($urandom_range(9) < 8)
          send_event(make_event(ACT_SEGMENT, 4'($urandom), port, 16'($urandom),
                                SEG_FIN));
        if ($urandom_range(3) == 0)
          send_event(make_event(ACT_SEGMENT, 4'($urandom), port, 16'($urandom),
                                2'($urandom)));
        if (tracker.close_ticks <= 16'd8)
          reps = $urandom_range(0, int'(tracker.close_ticks) + 1);
        else
          reps = $urandom_range(0, 3);
        repeat (reps)
          send_event(make_event(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                                2'($urandom)));
        if ($urandom_range(9) < 7)
          send_event(make_event(ACT_CLOSE, sid[3:0], 16'($urandom), 16'($urandom),
                                2'($urandom)));
      end else if (sel < 85) begin
        send_event(make_event(3'($urandom_range(7)), 4'($urandom), pick_port(),
                              16'($urandom), 2'($urandom)));
      end else if (sel < 95) begin
        reps = $urandom_range(1, 8);
        repeat (reps)
          send_event(make_event(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                                2'($urandom)));
      end else begin
        // overfill the table, then free part of it
        repeat (ENTRIES + 1)
          send_event(make_event(ACT_CREATE, 4'($urandom), pick_port(), 16'($urandom),
                                2'($urandom)));
        reps = $urandom_range(ENTRIES / 2, ENTRIES);
        repeat (reps)
          send_event(make_event(ACT_CLOSE, 4'($urandom_range(ENTRIES - 1)),
                                16'($urandom), 16'($urandom), 2'($urandom)));
      end
    end
  endtask

  initial begin
    logic [15:0] phase_ticks[6];
    tracker = new();
    phase_ticks = '{16'd1, 16'd3, 16'd65535, 16'd2, 16'($urandom_range(2, 8)), 16'd1000};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk one entry through every state with the reset timeout
    send_event(make_event(ACT_TICK, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_ACCEPT, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_CLOSE, 4'd15, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'h0000, 16'h0001, SEG_SYN));
    send_event(make_event(ACT_CREATE, 4'd0, 16'hFFFF, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_CREATE, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'h1234, SEG_SYN));
    send_event(make_event(ACT_ACCEPT, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'h1234, SEG_FIN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'h1234, 2'd1));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'hFFFF, SEG_SYN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'h0000, 2'd3));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'h0000, SEG_FIN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'hFFFF, 16'h0000, SEG_FIN));
    send_event(make_event(ACT_TICK, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(3'd5, 4'd15, 16'hFFFF, 16'hFFFF, 2'd3));
    send_event(make_event(ACT_ACCEPT, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_CLOSE, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_CLOSE, 4'd1, 16'h0000, 16'h0000, SEG_SYN));

    // A zero timeout expires on the first tick
    write_timeout(16'd0);
    send_event(make_event(ACT_CREATE, 4'd0, 16'h1234, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_ACCEPT, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'h1234, 16'h4321, SEG_SYN));
    send_event(make_event(ACT_SEGMENT, 4'd0, 16'h1234, 16'h4321, SEG_FIN));
    send_event(make_event(ACT_TICK, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(ACT_CLOSE, 4'd0, 16'h0000, 16'h0000, SEG_SYN));
    send_event(make_event(3'd7, 4'd0, 16'h0000, 16'h0000, SEG_SYN));

    // Random traffic under several timeouts; one phase runs without gaps
    foreach (phase_ticks[p]) begin
      write_timeout(phase_ticks[p]);
      allow_idle = (p != 1);
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
